@@ sv/ccw_pkg.sv @@
`default_nettype none
package ccw_pkg;

   localparam int SCREEN_WIDTH  = 80;
   localparam int SCREEN_HEIGHT = 25;

   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int ADDR_W  = 11;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int NUM_W   = 32;
   localparam int DIGIT_W = 4;
   localparam int MAX_DIGITS = 10;
   localparam int BCD_W   = MAX_DIGITS * DIGIT_W;
   localparam int BITCNT_W = $clog2(NUM_W + 1);
   localparam int DCNT_W   = $clog2(MAX_DIGITS + 1);

   localparam logic [1:0] OP_PUT_CHAR   = 2'd0;
   localparam logic [1:0] OP_PUT_NUMBER = 2'd1;
   localparam logic [1:0] OP_PUT_CELL   = 2'd2;

   localparam logic [CHAR_W-1:0] NEWLINE_CHAR    = 8'd10;
   localparam logic [CHAR_W-1:0] DIGIT_ZERO_CHAR = 8'd48;
   localparam logic [ATTR_W-1:0] TEXT_COLOR_RESET = 8'd7;

   typedef struct packed {
      logic [1:0]        operation;
      logic [CHAR_W-1:0] character;
      logic [NUM_W-1:0]  number;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic [ATTR_W-1:0] cell_color;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_W-1:0] cell_address;
      logic [CHAR_W-1:0] cell_character;
      logic [ATTR_W-1:0] cell_attribute;
      logic              last_of_run;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      MODE_CURSOR_CHAR,
      MODE_NUMBER,
      MODE_DIRECT
   } mode_type;

   typedef struct packed {
      logic load;
      logic step;
      logic scan;
      logic pop;
   } dab_cmd_type;

   typedef struct packed {
      logic               conv_done;
      logic               scan_done;
      logic [DIGIT_W-1:0] top_digit;
      logic [DCNT_W-1:0]  count;
   } dab_status_type;

   typedef struct packed {
      logic advance;
      logic newline;
   } cur_cmd_type;

endpackage
`default_nettype wire

@@ sv/ccw_dabble.sv @@
`default_nettype none
module ccw_dabble (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ccw_pkg::dab_cmd_type     cmd,
   input  wire logic [ccw_pkg::NUM_W-1:0] number,
   output ccw_pkg::dab_status_type       status
);

   logic [ccw_pkg::NUM_W-1:0]    num_ff, num_in;
   logic [ccw_pkg::BCD_W-1:0]    bcd_ff, bcd_in;
   logic [ccw_pkg::BITCNT_W-1:0] bit_ff, bit_in;
   logic [ccw_pkg::DCNT_W-1:0]   cnt_ff, cnt_in;
   logic [ccw_pkg::BCD_W-1:0]    bcd_adj;
   logic [ccw_pkg::DIGIT_W-1:0]  top_digit;
   logic                         scan_done;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < ccw_pkg::MAX_DIGITS; i++) begin
         if (bcd_ff[i*ccw_pkg::DIGIT_W +: ccw_pkg::DIGIT_W] >= 4'd5) begin
            bcd_adj[i*ccw_pkg::DIGIT_W +: ccw_pkg::DIGIT_W] =
               bcd_ff[i*ccw_pkg::DIGIT_W +: ccw_pkg::DIGIT_W] + 4'd3;
         end else begin
            bcd_adj[i*ccw_pkg::DIGIT_W +: ccw_pkg::DIGIT_W] =
               bcd_ff[i*ccw_pkg::DIGIT_W +: ccw_pkg::DIGIT_W];
         end
      end
   end

   assign top_digit = bcd_ff[ccw_pkg::BCD_W-1 -: ccw_pkg::DIGIT_W];
   assign scan_done = (top_digit != '0) || (cnt_ff == ccw_pkg::DCNT_W'(1));

   always_comb begin
      num_in = num_ff;
      bcd_in = bcd_ff;
      bit_in = bit_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         num_in = number;
         bcd_in = '0;
         bit_in = '0;
         cnt_in = ccw_pkg::DCNT_W'(ccw_pkg::MAX_DIGITS);
      end else if (cmd.step) begin
         bcd_in = {bcd_adj[ccw_pkg::BCD_W-2:0], num_ff[ccw_pkg::NUM_W-1]};
         num_in = {num_ff[ccw_pkg::NUM_W-2:0], 1'b0};
         bit_in = bit_ff + 1'b1;
      end else if ((cmd.scan && !scan_done) || cmd.pop) begin
         bcd_in = {bcd_ff[ccw_pkg::BCD_W-ccw_pkg::DIGIT_W-1:0], {ccw_pkg::DIGIT_W{1'b0}}};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      bcd_ff <= bcd_in;
      if (reset) begin
         bit_ff <= '0;
         cnt_ff <= '0;
      end else begin
         bit_ff <= bit_in;
         cnt_ff <= cnt_in;
      end
   end

   assign status.conv_done = (bit_ff == ccw_pkg::BITCNT_W'(ccw_pkg::NUM_W));
   assign status.scan_done = scan_done;
   assign status.top_digit = top_digit;
   assign status.count     = cnt_ff;

endmodule
`default_nettype wire

@@ sv/ccw_cursor.sv @@
`default_nettype none
module ccw_cursor (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ccw_pkg::cur_cmd_type       cmd,
   input  wire logic                       direct,
   input  wire logic [ccw_pkg::ROW_W-1:0]  direct_row,
   input  wire logic [ccw_pkg::COL_W-1:0]  direct_column,
   output logic [ccw_pkg::ADDR_W-1:0]      address
);

   logic [ccw_pkg::ROW_W-1:0] row_ff, row_in, row_next;
   logic [ccw_pkg::COL_W-1:0] col_ff, col_in;
   logic [ccw_pkg::ROW_W-1:0] sel_row;
   logic [ccw_pkg::COL_W-1:0] sel_col;

   assign row_next = (row_ff == ccw_pkg::ROW_W'(ccw_pkg::SCREEN_HEIGHT - 1)) ?
                     '0 : row_ff + 1'b1;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.newline) begin
         row_in = row_next;
         col_in = '0;
      end else if (cmd.advance) begin
         if (col_ff == ccw_pkg::COL_W'(ccw_pkg::SCREEN_WIDTH - 1)) begin
            row_in = row_next;
            col_in = '0;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign sel_row = direct ? direct_row : row_ff;
   assign sel_col = direct ? direct_column : col_ff;
   assign address = ccw_pkg::ADDR_W'(32'(sel_row) * 32'(ccw_pkg::SCREEN_WIDTH)
                                     + 32'(sel_col));

endmodule
`default_nettype wire

@@ sv/text_console_cell_writer_top.sv @@
`default_nettype none
// Text console writer: each word on req_ turns into zero or more cell writes on rsp_
// (address row*80+column, character, attribute, last_of_run on the final one). For a number
// word, a bit-serial double-dabble register converts the 32-bit value in 32 steps, then
// drops leading zero digits one per cycle before the digits are sent, most significant
// first. The last result sits in the output register while the next word is accepted.
// text_color is written through csr_ and takes effect on later cursor writes.
module text_console_cell_writer_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire ccw_pkg::req_word_type           req_word,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output ccw_pkg::rsp_word_type                rsp_word,
   input  wire logic                            csr_write_enable,
   input  wire logic [ccw_pkg::ATTR_W-1:0]      csr_write_data
);

   ccw_pkg::state_type      state_ff, state_in;
   ccw_pkg::mode_type       mode_ff, mode_in;
   logic [ccw_pkg::CHAR_W-1:0] char_ff;
   logic [ccw_pkg::ATTR_W-1:0] attr_ff;
   logic [ccw_pkg::ROW_W-1:0]  row_ff;
   logic [ccw_pkg::COL_W-1:0]  col_ff;
   logic [ccw_pkg::ATTR_W-1:0] text_color_ff;
   logic                       rsp_valid_ff;
   ccw_pkg::rsp_word_type      rsp_word_ff, rsp_word_in;

   ccw_pkg::dab_cmd_type    dab_cmd;
   ccw_pkg::dab_status_type dab_status;
   ccw_pkg::cur_cmd_type    cur_cmd;
   logic [ccw_pkg::ADDR_W-1:0] cur_address;

   logic accept;
   logic on_screen;
   logic out_free;
   logic load_out;
   logic last;

   assign req_stall = (state_ff != ccw_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign on_screen = (32'(req_word.column) < 32'(ccw_pkg::SCREEN_WIDTH)) &&
                      (32'(req_word.row) < 32'(ccw_pkg::SCREEN_HEIGHT));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last      = (mode_ff != ccw_pkg::MODE_NUMBER) ||
                      (dab_status.count == ccw_pkg::DCNT_W'(1));

   ccw_dabble u_dabble (
      .clock  (clock),
      .reset  (reset),
      .cmd    (dab_cmd),
      .number (req_word.number),
      .status (dab_status)
   );

   ccw_cursor u_cursor (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cur_cmd),
      .direct        (mode_ff == ccw_pkg::MODE_DIRECT),
      .direct_row    (row_ff),
      .direct_column (col_ff),
      .address       (cur_address)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      case (state_ff)
         ccw_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_word.operation)
                  ccw_pkg::OP_PUT_CHAR: begin
                     if (req_word.character != ccw_pkg::NEWLINE_CHAR) begin
                        mode_in  = ccw_pkg::MODE_CURSOR_CHAR;
                        state_in = ccw_pkg::ST_EMIT;
                     end
                  end
                  ccw_pkg::OP_PUT_NUMBER: begin
                     mode_in  = ccw_pkg::MODE_NUMBER;
                     state_in = ccw_pkg::ST_CONVERT;
                  end
                  ccw_pkg::OP_PUT_CELL: begin
                     if (on_screen) begin
                        mode_in  = ccw_pkg::MODE_DIRECT;
                        state_in = ccw_pkg::ST_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ccw_pkg::ST_CONVERT: begin
            if (dab_status.conv_done) begin
               state_in = ccw_pkg::ST_SCAN;
            end
         end
         ccw_pkg::ST_SCAN: begin
            if (dab_status.scan_done) begin
               state_in = ccw_pkg::ST_EMIT;
            end
         end
         ccw_pkg::ST_EMIT: begin
            if (out_free && last) begin
               state_in = ccw_pkg::ST_IDLE;
            end
         end
         default: state_in = ccw_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      dab_cmd  = '0;
      cur_cmd  = '0;
      load_out = 1'b0;
      case (state_ff)
         ccw_pkg::ST_IDLE: begin
            if (accept && req_word.operation == ccw_pkg::OP_PUT_CHAR &&
                req_word.character == ccw_pkg::NEWLINE_CHAR) begin
               cur_cmd.newline = 1'b1;
            end
            if (accept && req_word.operation == ccw_pkg::OP_PUT_NUMBER) begin
               dab_cmd.load = 1'b1;
            end
         end
         ccw_pkg::ST_CONVERT: begin
            dab_cmd.step = !dab_status.conv_done;
         end
         ccw_pkg::ST_SCAN: begin
            dab_cmd.scan = 1'b1;
         end
         ccw_pkg::ST_EMIT: begin
            load_out        = out_free;
            cur_cmd.advance = out_free && (mode_ff != ccw_pkg::MODE_DIRECT);
            dab_cmd.pop     = out_free && (mode_ff == ccw_pkg::MODE_NUMBER);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_word_in.cell_address = cur_address;
      rsp_word_in.last_of_run  = last;
      case (mode_ff)
         ccw_pkg::MODE_NUMBER: begin
            rsp_word_in.cell_character = ccw_pkg::DIGIT_ZERO_CHAR +
                                         ccw_pkg::CHAR_W'(dab_status.top_digit);
            rsp_word_in.cell_attribute = text_color_ff;
         end
         ccw_pkg::MODE_DIRECT: begin
            rsp_word_in.cell_character = char_ff;
            rsp_word_in.cell_attribute = attr_ff;
         end
         default: begin
            rsp_word_in.cell_character = char_ff;
            rsp_word_in.cell_attribute = text_color_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_word.character;
         attr_ff <= req_word.cell_color;
         row_ff  <= req_word.row;
         col_ff  <= req_word.column;
      end
      if (load_out) begin
         rsp_word_ff <= rsp_word_in;
      end
      if (reset) begin
         state_ff      <= ccw_pkg::ST_IDLE;
         mode_ff       <= ccw_pkg::MODE_CURSOR_CHAR;
         text_color_ff <= ccw_pkg::TEXT_COLOR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         if (csr_write_enable) begin
            text_color_ff <= csr_write_data;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_convert_to_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ccw_pkg::ST_CONVERT && dab_status.conv_done)
      |=> (state_ff == ccw_pkg::ST_SCAN))
      else $error("conversion did not hand over to digit scan");

   a_digits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ccw_pkg::ST_EMIT && mode_ff == ccw_pkg::MODE_NUMBER)
      |-> (dab_status.count != '0))
      else $error("digit emission with no digits left");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (load_out && last) |=> (state_ff == ccw_pkg::ST_IDLE && rsp_valid_ff &&
                              rsp_word_ff.last_of_run))
      else $error("final word did not end the run");

endmodule
`default_nettype wire
